/* rtl/assert_macros.svh */
// assertion macros included by the rtl sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication with the consequent checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/u2da_pkg.sv */
// shared constants and types of the binary to decimal ascii converter
package u2da_pkg;

	localparam int VAL_W   = 64;
	localparam int DIGITS  = 20;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 6;
	localparam int CNT_W   = $clog2(VAL_W);
	localparam int REM_W   = $clog2(DIGITS + 1);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

	// control handed from the sequencer to every digit cell
	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift;
	} cell_ctl_t;

endpackage

/* rtl/u2da_cell.sv */
// one bcd digit cell of the double dabble chain
module u2da_cell
	import u2da_pkg::*;
(
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic               bit_in,
	input  logic [DIGIT_W-1:0] digit_in,
	output logic               carry_out,
	output logic [DIGIT_W-1:0] digit
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// add three before the shift when the digit would overflow past nine
	assign adj = (digit_q >= DABBLE_LIMIT) ? digit_q + DABBLE_ADD : digit_q;
	assign carry_out = adj[DIGIT_W-1];
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (ctl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

/* rtl/u2da_seq.sv */
// sequencer: conversion count, digit emission and output registers
`include "assert_macros.svh"

module u2da_seq
	import u2da_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIGIT_W-1:0] top_digit,
	output logic               busy,
	output cell_ctl_t          ctl,
	output logic               strobe,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last_digit
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	localparam logic [CHAR_W-1:0] ASCII_NINE = ASCII_ZERO + CHAR_W'(9);

	state_t             state_q;
	logic [CNT_W-1:0]   bit_cnt_q;
	logic [REM_W-1:0]   remain_q;
	logic               lead_q;
	logic               strobe_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               accept;
	logic               emit;
	logic               final_digit;
	logic               last_step;
	logic               char_ok;

	assign accept      = start && (state_q == ST_IDLE);
	assign final_digit = (remain_q == REM_W'(1));
	// leading zeros are skipped, but the units digit always goes out
	assign emit        = !(lead_q && (top_digit == '0) && !final_digit);

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: ctl.clear  = start;
			ST_CONV: ctl.dabble = 1'b1;
			ST_EMIT: ctl.shift  = 1'b1;
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			remain_q  <= '0;
			lead_q    <= 1'b0;
			strobe_q  <= 1'b0;
			char_q    <= ASCII_ZERO;
			last_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= '0;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + CNT_W'(1);
					if (bit_cnt_q == CNT_W'(VAL_W - 1)) begin
						state_q  <= ST_EMIT;
						remain_q <= REM_W'(DIGITS);
						lead_q   <= 1'b1;
					end
				end
				ST_EMIT: begin
					remain_q <= remain_q - REM_W'(1);
					if (emit) begin
						strobe_q <= 1'b1;
						char_q   <= ASCII_ZERO + CHAR_W'(top_digit);
						last_q   <= final_digit;
						lead_q   <= 1'b0;
					end
					if (final_digit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

	assign last_step = (state_q == ST_EMIT) && final_digit;
	assign char_ok   = (char_q >= ASCII_ZERO) && (char_q <= ASCII_NINE);

	`ASSERT_CLK(a_char_range, !strobe_q || char_ok, "digit out of range")
	`ASSERT_NEXT(a_last_ends_run, strobe_q && last_q, !strobe_q, "beat after last digit")
	`ASSERT_NEXT(a_units_emitted, last_step, strobe_q && last_q && !busy, "no units digit")
	`ASSERT_NEXT(a_start_busy, accept, busy && !strobe_q, "start not taken")
	`ASSERT_CLK(a_last_only_emit, !last_q || strobe_q, "last flag without beat")

endmodule

/* rtl/unsigned_to_decimal_ascii.sv */
// top level: 64-bit unsigned to decimal ascii digits, msd first
// usage:
//   drive value and pulse start while busy is low; the value is taken at
//   that clock edge and busy rises in the next cycle
//   the value is shifted msb first into a chain of twenty bcd digit cells,
//   one bit per cycle, in a 64-step conversion
//   the digit chain then shifts one digit per cycle toward the top cell,
//   a 20-step readout; leading zero digits are dropped, the rest leave as beats
//   each beat shows digit_char and last_digit with strobe high for exactly
//   one cycle; last_digit marks the units digit, zero gives a single '0'
//   the first beat follows the conversion and any dropped leading zeros,
//   the last beat ends the readout; a new value is accepted only once the
//   previous one is through the 64-step conversion and the 20-step readout
//   there is no flow control on the results: the receiver takes every beat
//   reset clears the sequencer; no beat is pending after reset
module unsigned_to_decimal_ascii
	import u2da_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [VAL_W-1:0]  value,
	output logic              busy,
	output logic              strobe,
	output logic [CHAR_W-1:0] digit_char,
	output logic              last_digit
);

	cell_ctl_t          ctl;
	logic [VAL_W-1:0]   value_q;
	logic [DIGITS-1:0]  carry;
	logic [DIGIT_W-1:0] digits [DIGITS];

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			value_q <= value;
		end else if (ctl.dabble) begin
			value_q <= {value_q[VAL_W-2:0], 1'b0};
		end
	end

	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		logic               bit_in;
		logic [DIGIT_W-1:0] digit_in;
		if (i == 0) begin : g_first
			assign bit_in   = value_q[VAL_W-1];
			assign digit_in = '0;
		end else begin : g_rest
			assign bit_in   = carry[i-1];
			assign digit_in = digits[i-1];
		end
		u2da_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.bit_in    (bit_in),
			.digit_in  (digit_in),
			.carry_out (carry[i]),
			.digit     (digits[i])
		);
	end

	u2da_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.top_digit  (digits[DIGITS-1]),
		.busy       (busy),
		.ctl        (ctl),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

endmodule

/* tb/sv/unsigned_to_decimal_ascii_tb.sv */
`timescale 1ns / 100ps
// testbench for the 64-bit unsigned to decimal ascii converter
module unsigned_to_decimal_ascii_tb;
	import u2da_pkg::*;

	localparam int MAX_CYCLES   = 400000;
	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_ITEMS = 110;
	localparam int DECIMAL_BASE = 10;
	localparam int IDLE_PCT     = 7;
	localparam int CALM_FIRST   = 45;
	localparam int CALM_LAST    = 85;

	typedef struct {
		logic [VAL_W-1:0] val;
		bit               wait_drain;
	} conv_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [VAL_W-1:0]  value = '0;
	logic              busy;
	logic              strobe;
	logic [CHAR_W-1:0] digit_char;
	logic              last_digit;

	conv_req_t   req_q[$];
	digit_beat_t digit_q[$];
	int          errors = 0;
	int          accepted = 0;
	int          cycles = 0;
	int          gap_left = 0;

	unsigned_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.strobe    (strobe),
		.digit_char(digit_char),
		.last_digit(last_digit)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [VAL_W-1:0] pow10(input int k);
		logic [VAL_W-1:0] p;
		p = 1;
		repeat (k) p = p * DECIMAL_BASE;
		return p;
	endfunction

	// expected digit beats of one value, msd first, lsd flagged last
	task automatic push_decimal_digits(input logic [VAL_W-1:0] v);
		digit_beat_t      beats[$];
		digit_beat_t      b;
		logic [VAL_W-1:0] rest;
		logic [DIGIT_W-1:0] d;
		rest = v;
		do begin
			d = DIGIT_W'(rest % DECIMAL_BASE);
			b.ch = ASCII_ZERO + CHAR_W'(d);
			b.last = (beats.size() == 0);
			beats.push_front(b);
			rest = rest / DECIMAL_BASE;
		end while (rest != 0);
		foreach (beats[i]) digit_q.push_back(beats[i]);
	endtask

	task automatic add_item(input logic [VAL_W-1:0] v, input bit drain);
		conv_req_t r;
		r.val = v;
		r.wait_drain = drain;
		req_q.push_back(r);
	endtask

	// driver: start stays up until the value is taken
	always @(posedge clk or negedge arst_n) begin
		logic go;
		if (!arst_n) begin
			start <= 1'b0;
			value <= '0;
		end else begin
			go = start;
			if (start && !busy) begin
				push_decimal_digits(value);
				accepted++;
				go = 1'b0;
			end
			if (!go && req_q.size() != 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if ((accepted < CALM_FIRST || accepted > CALM_LAST) &&
						$urandom_range(99) < IDLE_PCT) begin
					// random gap so the next start lands on any phase of the work
					gap_left = $urandom_range(90);
				end else if (!(req_q[0].wait_drain && digit_q.size() != 0)) begin
					value <= req_q[0].val;
					req_q.pop_front();
					go = 1'b1;
				end
			end
			start <= go;
		end
	end

	// monitor: every strobe is one digit beat
	always @(posedge clk) begin
		digit_beat_t want;
		if (arst_n && strobe === 1'b1) begin
			if (digit_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %0d/%0b",
					$time, digit_char, last_digit);
				errors++;
			end else begin
				want = digit_q.pop_front();
				if (digit_char !== want.ch) begin
					$display("%0t: digit_char mismatch, expected %0d, actual %0d",
						$time, want.ch, digit_char);
					errors++;
				end
				if (last_digit !== want.last) begin
					$display("%0t: last_digit mismatch, expected %0b, actual %0b",
						$time, want.last, last_digit);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [VAL_W-1:0] v;
		int               n;
		int               k;

		add_item('0, 1'b0);
		add_item(64'd1, 1'b0);
		add_item(64'd9, 1'b0);
		add_item(64'd10, 1'b0);
		add_item(64'd99, 1'b0);
		add_item(64'd100, 1'b0);
		add_item('1, 1'b0);
		add_item('1 - 1, 1'b1);
		add_item(pow10(19), 1'b0);
		add_item(pow10(19) - 1, 1'b0);
		add_item(64'h8000_0000_0000_0000, 1'b0);
		add_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		add_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		add_item(64'h5555_5555_5555_5555, 1'b0);
		add_item(64'h0000_0000_FFFF_FFFF, 1'b0);
		add_item(64'h0000_0001_0000_0000, 1'b0);
		add_item(64'd12345678901234567890, 1'b0);
		add_item(64'd9876543210, 1'b0);
		add_item(pow10(10), 1'b1);
		add_item(pow10(18) + 1, 1'b0);
		add_item(64'd1000000007, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			v = {$urandom, $urandom};
			case ($urandom_range(9)) inside
				[0:5]: begin
					// spread bit lengths evenly
					n = $urandom_range(1, VAL_W);
					v = v >> (VAL_W - n);
				end
				6: begin
					k = $urandom_range(0, DIGITS - 1);
					v = pow10(k) + $urandom_range(2) - 1;
				end
				7: v = $urandom_range(DECIMAL_BASE - 1);
				default: ;
			endcase
			add_item(v, $urandom_range(29) == 0);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || start || digit_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/u2da_pkg.sv
rtl/u2da_cell.sv
rtl/u2da_seq.sv
rtl/unsigned_to_decimal_ascii.sv
tb/sv/unsigned_to_decimal_ascii_tb.sv
